// ----- sv/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    // Width of the hue field and number of fraction bits inside it.
    localparam int HUE_W         = 11;
    localparam int HUE_FRAC_BITS = 8;

    // Width of s*f and s*(F-f) before the fraction is dropped.
    localparam int PROD_W = 8 + HUE_FRAC_BITS + 1;

    // F = 2^HUE_FRAC_BITS, one full sector of hue.
    localparam logic [HUE_FRAC_BITS:0] HUE_ONE = {1'b1, {HUE_FRAC_BITS{1'b0}}};

    // Hue sectors of the six-sector color wheel.
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;
    localparam logic [3:0] SEC_COUNT   = 4'd6;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [7:0]       saturation;
        logic [7:0]       brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // Sector field of the hue taken modulo six, one bit at a time from the top.
    // Only the bits above the fraction take part.
    function automatic logic [2:0] sector_of(logic [HUE_W-1:0] hue);
        logic [3:0] rem;
        rem = '0;
        for (int i = HUE_W - 1; i >= 0; i--) begin
            if (i >= HUE_FRAC_BITS) begin
                rem = {rem[2:0], hue[i]};
                if (rem >= SEC_COUNT) begin
                    rem = rem - SEC_COUNT;
                end
            end
        end
        return rem[2:0];
    endfunction

    // Truncating division by 255 for any product of two 8-bit values.
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// ----- sv/hsv_to_rgb_converter_top.sv -----
// HSV to RGB pixel converter. A pixel transfer on the hsv channel carries a fixed-point
// hue (sector in the bits above the low HUE_FRAC_BITS fraction bits, sectors beyond five
// wrap modulo six), a saturation and a brightness; each one gives exactly one transfer of
// an 8-bit red, green and blue triple on the rgb channel, in order. The block is a
// four-stage pipeline: fraction products, brightness products, division by 255, and
// sector selection into the output register. It takes one pixel every clock cycle while
// hsv_stall is low, and each pixel passes stages one, two and three and then the output
// register in order. Both channels use valid and stall; a stall from the rgb side holds only
// the stages that are full, so empty stages keep filling and no pixel is lost or repeated.
// There are no registers to program and no state carried from one pixel to the next.
module hsv_to_rgb_converter_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hsv_valid,
    output logic                    hsv_stall,
    input  hsv2rgb_pkg::hsv_pixel_t hsv,
    output logic                    rgb_valid,
    input  logic                    rgb_stall,
    output hsv2rgb_pkg::rgb_pixel_t rgb
);
    import hsv2rgb_pkg::*;

    // Stage one: saturation times the hue fraction and its complement.
    logic                     s1_valid_reg;
    logic [7:0]               s1_v_reg;
    logic [7:0]               s1_kp_reg;
    logic [PROD_W-1:0]        s1_sq_reg;
    logic [PROD_W-1:0]        s1_st_reg;
    logic [2:0]               s1_sect_reg;

    // Stage two: brightness times the three scale factors.
    logic                     s2_valid_reg;
    logic [7:0]               s2_v_reg;
    logic [2:0]               s2_sect_reg;
    logic [15:0]              s2_xp_reg;
    logic [15:0]              s2_xq_reg;
    logic [15:0]              s2_xt_reg;

    // Stage three: the four candidate channel levels.
    logic                     s3_valid_reg;
    logic [7:0]               s3_z_reg;
    logic [7:0]               s3_p_reg;
    logic [7:0]               s3_q_reg;
    logic [7:0]               s3_t_reg;
    logic [2:0]               s3_sect_reg;

    // Output register.
    logic                     rgb_valid_reg;
    rgb_pixel_t               rgb_reg;
    rgb_pixel_t               rgb_next;

    // A stage advances when it is empty or the stage after it advances, so a
    // stall holds only the full part of the pipeline.
    logic rgb_adv, s3_adv, s2_adv, s1_adv;

    assign rgb_adv   = !rgb_valid_reg || !rgb_stall;
    assign s3_adv    = !s3_valid_reg || rgb_adv;
    assign s2_adv    = !s2_valid_reg || s3_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign hsv_stall = !s1_adv;

    // Stage one combinational work.
    logic [HUE_FRAC_BITS-1:0] frac;
    logic [HUE_FRAC_BITS:0]   frac_comp;

    assign frac      = HUE_FRAC_BITS'(hsv.hue);
    assign frac_comp = HUE_ONE - {1'b0, frac};

    // Stage two combinational work: scale factors with the fraction dropped.
    logic [7:0] kq, kt;

    assign kq = 8'd255 - 8'(s1_sq_reg >> HUE_FRAC_BITS);
    assign kt = 8'd255 - 8'(s1_st_reg >> HUE_FRAC_BITS);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= hsv_valid;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rgb_adv) begin
                rgb_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers. Zero saturation needs no special path: all three
    // factors become 255 and every channel comes out at the brightness.
    always_ff @(posedge clk) begin
        if (s1_adv && hsv_valid) begin
            s1_v_reg    <= hsv.brightness;
            s1_kp_reg   <= 8'd255 - hsv.saturation;
            s1_sq_reg   <= PROD_W'(hsv.saturation) * PROD_W'(frac);
            s1_st_reg   <= PROD_W'(hsv.saturation) * PROD_W'(frac_comp);
            s1_sect_reg <= sector_of(hsv.hue);
        end
        if (s2_adv && s1_valid_reg) begin
            s2_v_reg    <= s1_v_reg;
            s2_sect_reg <= s1_sect_reg;
            s2_xp_reg   <= 16'(s1_v_reg) * 16'(s1_kp_reg);
            s2_xq_reg   <= 16'(s1_v_reg) * 16'(kq);
            s2_xt_reg   <= 16'(s1_v_reg) * 16'(kt);
        end
        if (s3_adv && s2_valid_reg) begin
            s3_z_reg    <= s2_v_reg;
            s3_p_reg    <= div255(s2_xp_reg);
            s3_q_reg    <= div255(s2_xq_reg);
            s3_t_reg    <= div255(s2_xt_reg);
            s3_sect_reg <= s2_sect_reg;
        end
        if (rgb_adv && s3_valid_reg) begin
            rgb_reg <= rgb_next;
        end
    end

    // Standard six-sector table.
    always_comb begin
        case (s3_sect_reg)
            SEC_RED_YEL: rgb_next = '{red: s3_z_reg, green: s3_t_reg, blue: s3_p_reg};
            SEC_YEL_GRN: rgb_next = '{red: s3_q_reg, green: s3_z_reg, blue: s3_p_reg};
            SEC_GRN_CYN: rgb_next = '{red: s3_p_reg, green: s3_z_reg, blue: s3_t_reg};
            SEC_CYN_BLU: rgb_next = '{red: s3_p_reg, green: s3_q_reg, blue: s3_z_reg};
            SEC_BLU_MAG: rgb_next = '{red: s3_t_reg, green: s3_p_reg, blue: s3_z_reg};
            default:     rgb_next = '{red: s3_z_reg, green: s3_p_reg, blue: s3_q_reg};
        endcase
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

    // The grey floor p never exceeds the ramps, and no ramp exceeds the brightness.
    a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_p_reg <= s3_q_reg) && (s3_p_reg <= s3_t_reg) &&
                         (s3_q_reg <= s3_z_reg) && (s3_t_reg <= s3_z_reg))
        else $error("channel levels out of order in stage three");

    // A held stage three keeps its pixel until the output takes it.
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_adv) |=> s3_valid_reg && $stable(s3_p_reg) &&
                                      $stable(s3_q_reg) && $stable(s3_t_reg) &&
                                      $stable(s3_sect_reg))
        else $error("stalled stage three lost its pixel");

    // Every accepted pixel lands in stage one.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall) |=> s1_valid_reg)
        else $error("accepted pixel did not enter the pipeline");

endmodule
